/* rtl/core/dfr_pkg.sv */
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, request and register codes, the result record and the
// store port record of the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int FRAME_MAX   = 64;
	localparam int STORE_DEPTH = FRAME_MAX + 1;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int REQ_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 7;
	localparam int LEN_W   = 7;
	localparam int POS_W   = $clog2(FRAME_MAX + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_RX      = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEGIN  = 2'd0,
		REG_END    = 2'd1,
		REG_SPARE2 = 2'd2,
		REG_SPARE3 = 2'd3
	} cfg_reg_t;

	// Result of one step, minus the stored byte that the RAM returns later.
	typedef struct packed {
		logic             frame_ready;
		logic [LEN_W-1:0] frame_len;
		logic             byte_taken;
		logic             buffer_overrun;
		logic             restart_timeout;
		logic             rd_hit;
	} res_t;

	// Port toward the frame store.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

/* rtl/core/dfr_frame_ram.sv */
// ----------------------------------------------------------------------------
// dfr_frame_ram
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dfr_frame_ram (
	input  logic                          clk,
	input  dfr_pkg::mem_req_t             mreq,
	output logic [dfr_pkg::BYTE_W-1:0]    rdata
);
	import dfr_pkg::*;

	logic [BYTE_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (mreq.re) begin
			rdata <= mem[mreq.raddr];
		end
	end

endmodule

/* rtl/core/dfr_ctrl.sv */
// ----------------------------------------------------------------------------
// dfr_ctrl
// Delimiter decode, write position, pending flag and latched length; drives
// the frame store write and read ports for each accepted request.
// ----------------------------------------------------------------------------
module dfr_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             accept,
	input  logic [dfr_pkg::REQ_W-1:0]        req_type,
	input  logic [dfr_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                             line_error,
	input  logic [dfr_pkg::INDEX_W-1:0]      read_index,
	output dfr_pkg::res_t                    res,
	output dfr_pkg::mem_req_t                mreq
);
	import dfr_pkg::*;

	logic [BYTE_W-1:0] begin_byte_q;
	logic [BYTE_W-1:0] end_byte_q;
	logic [POS_W-1:0]  write_pos_q;
	logic              pending_q;
	logic [LEN_W-1:0]  len_q;

	logic [POS_W-1:0]  pos_d;
	logic              pending_d;
	logic [LEN_W-1:0]  len_d;
	logic              store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_byte_q <= BYTE_W'(2);
			end_byte_q   <= BYTE_W'(3);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BEGIN: begin_byte_q <= cfg_data[BYTE_W-1:0];
				REG_END:   end_byte_q   <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_d     = write_pos_q;
		pending_d = pending_q;
		len_d     = len_q;
		store     = 1'b0;
		res       = '0;
		case (req_t'(req_type))
			REQ_RX: begin
				if (!line_error && !pending_q) begin
					res.restart_timeout = 1'b1;
					if (rx_byte == begin_byte_q) begin
						// Begin byte mid-frame: resync without storing.
						if (write_pos_q != '0) begin
							pos_d = '0;
						end else begin
							store = 1'b1;
							pos_d = POS_W'(1);
						end
					end else if (rx_byte == end_byte_q) begin
						store     = 1'b1;
						pending_d = 1'b1;
						len_d     = LEN_W'(write_pos_q) + LEN_W'(1);
						pos_d     = '0;
					end else if (write_pos_q >= POS_W'(FRAME_MAX)) begin
						pos_d              = '0;
						res.buffer_overrun = 1'b1;
					end else begin
						store = 1'b1;
						pos_d = write_pos_q + POS_W'(1);
					end
				end
			end
			REQ_READ:    res.rd_hit = (read_index < INDEX_W'(len_q));
			REQ_RELEASE: pending_d = 1'b0;
			default: ;
		endcase
		res.byte_taken  = store;
		res.frame_ready = pending_d;
		res.frame_len   = len_d;
	end

	always_comb begin
		mreq.we    = accept && store;
		mreq.waddr = ADDR_W'(write_pos_q);
		mreq.wdata = rx_byte;
		mreq.re    = accept && res.rd_hit;
		mreq.raddr = read_index[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			pending_q   <= 1'b0;
			len_q       <= '0;
		end else if (accept) begin
			write_pos_q <= pos_d;
			pending_q   <= pending_d;
			len_q       <= len_d;
		end
	end

endmodule

/* rtl/core/dfr_out_stage.sv */
// ----------------------------------------------------------------------------
// dfr_out_stage
// Result pipeline: stage 1 waits for the store read, then an output register
// holds the finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module dfr_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dfr_pkg::res_t                 res,
	input  logic [dfr_pkg::BYTE_W-1:0]    mem_rdata,
	output logic                          can_push,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dfr_pkg::res_t                 res_out,
	output logic [dfr_pkg::BYTE_W-1:0]    rdata_out
);
	import dfr_pkg::*;

	logic  valid_s1;
	res_t  res_s1;
	logic  valid_q;
	logic  move;

	assign move      = valid_s1 && (!valid_q || out_ready);
	assign can_push  = !valid_s1 || move;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (can_push) begin
				valid_s1 <= push;
			end
			if (move) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_push) begin
			res_s1 <= res;
		end
		if (move) begin
			res_out   <= res_s1;
			rdata_out <= res_s1.rd_hit ? mem_rdata : '0;
		end
	end

endmodule

/* rtl/core/delimited_frame_receiver.sv */
// Result path: an accepted transfer enters stage 1 with its store read, then the output register.
// Throughput: one request per cycle while out_ready keeps up; the frame store
// is read and written once per cycle; a request enters while a result waits.
// Reset: arst_n clears position, pending flag, length and the pipeline and
// loads the delimiters (begin 0x02, end 0x03); store contents stay undefined.
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Serial frame assembler delimited by configurable begin and end bytes, with
// indexed read-back of the stored frame and an explicit release.
// ----------------------------------------------------------------------------
module delimited_frame_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [dfr_pkg::REQ_W-1:0]        req_type,
	input  logic [dfr_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                             line_error,
	input  logic [dfr_pkg::INDEX_W-1:0]      read_index,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             frame_ready,
	output logic [dfr_pkg::LEN_W-1:0]        frame_len,
	output logic [dfr_pkg::BYTE_W-1:0]       read_data,
	output logic                             byte_taken,
	output logic                             buffer_overrun,
	output logic                             restart_timeout
);
	import dfr_pkg::*;

	logic              accept;
	res_t              res;
	res_t              res_out;
	mem_req_t          mreq;
	logic [BYTE_W-1:0] mem_rdata;

	// A transfer is taken whenever stage 1 is free or drains this cycle.
	assign accept = in_valid && in_ready;

	// Control state lives in flops; every accepted transfer updates it at
	// once, so the next request sees the new position and length.
	dfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.line_error (line_error),
		.read_index (read_index),
		.res        (res),
		.mreq       (mreq)
	);

	// Writes land at the accept edge; a read in any later transfer sees them,
	// so no forwarding path is needed.
	dfr_frame_ram u_ram (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (mem_rdata)
	);

	// Hold the read data until stage 1 advances; drop it to zero on misses.
	dfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.res       (res),
		.mem_rdata (mem_rdata),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out),
		.rdata_out (read_data)
	);

	assign frame_ready     = res_out.frame_ready;
	assign frame_len       = res_out.frame_len;
	assign byte_taken      = res_out.byte_taken;
	assign buffer_overrun  = res_out.buffer_overrun;
	assign restart_timeout = res_out.restart_timeout;

endmodule
